/* rtl/plid_pkg.sv */
// shared types and constants for the positional insert/delete list
// no dependencies; imported by plid_ctrl, plid_dp and the top level
package plid_pkg;

	localparam int VAL_W     = 32;
	localparam int POS_W     = 6;
	localparam int IDX_W     = 5;
	localparam int CNT_OUT_W = 6;
	localparam int DUMP_MAX  = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_DUMP   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
	} plid_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dump_go;
		logic dump_end;
	} plid_sts_t;

endpackage

/* rtl/plid_ctrl.sv */
// controller state machine for the positional insert/delete list
// depends on plid_pkg; drives plid_dp through plid_cmd_t
module plid_ctrl import plid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  plid_sts_t sts,
	output plid_cmd_t cmd,
	output logic      busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.dump_go ? S_DUMP : S_IDLE;
			end
			S_DUMP: begin
				cmd.step = 1'b1;
				if (sts.dump_end) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/plid_dp.sv */
// datapath: row of shifting cells, entry count, dump counter, result register
// depends on plid_pkg; commanded by plid_ctrl
module plid_dp import plid_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  plid_cmd_t                   cmd,
	output plid_sts_t                   sts,
	input  logic [1:0]                  kind,
	input  logic [POS_W-1:0]            position,
	input  logic signed [VAL_W-1:0]     value,
	output logic                        res_valid,
	output logic signed [VAL_W-1:0]     res_value,
	output logic [IDX_W-1:0]            res_index,
	output logic [1:0]                  res_status,
	output logic                        res_last,
	output logic [$clog2(DEPTH+1)-1:0]  count
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 2;

	kind_t              kind_q;
	logic [POS_W-1:0]   pos_q;
	logic [VAL_W-1:0]   val_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [VAL_W-1:0]   cell_q [DEPTH];
	logic [VAL_W-1:0]   cell_d [DEPTH];
	logic [VAL_W-1:0]   up_nb  [DEPTH];
	logic [VAL_W-1:0]   dn_nb  [DEPTH];

	logic [CMPW-1:0] cnt_x, pos_x, idx_x, nlim_x;
	logic            full, ins_ok, del_ok, do_ins, do_del, do_rot;

	assign cnt_x  = CMPW'(count_q);
	assign pos_x  = CMPW'(pos_q);
	assign idx_x  = CMPW'(idx_q);
	assign nlim_x = (cnt_x > CMPW'(DUMP_MAX)) ? CMPW'(DUMP_MAX) : cnt_x;

	assign full   = (cnt_x >= CMPW'(DEPTH));
	assign ins_ok = !full && (pos_x <= cnt_x);
	assign del_ok = (pos_x < cnt_x);
	assign do_ins = cmd.exec && (kind_q == KIND_INSERT) && ins_ok;
	assign do_del = cmd.exec && (kind_q == KIND_DELETE) && del_ok;
	assign do_rot = cmd.step;

	assign sts.dump_go  = (kind_q == KIND_DUMP) && (count_q != '0);
	assign sts.dump_end = (idx_x + CMPW'(1) == cnt_x);

	assign count = count_q;

	// neighbor taps, tied off at the ends of the row
	for (genvar g = 0; g < DEPTH; g++) begin : g_nb
		if (g > 0) begin : g_up
			assign up_nb[g] = cell_q[g-1];
		end else begin : g_up0
			assign up_nb[g] = '0;
		end
		if (g < DEPTH - 1) begin : g_dn
			assign dn_nb[g] = cell_q[g+1];
		end else begin : g_dnz
			assign dn_nb[g] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			if (do_ins) begin
				if (CMPW'(i) == pos_x) begin
					cell_d[i] = val_q;
				end else if (CMPW'(i) > pos_x && CMPW'(i) <= cnt_x) begin
					cell_d[i] = up_nb[i];
				end
			end else if (do_del) begin
				if (CMPW'(i) >= pos_x && CMPW'(i) + CMPW'(1) < cnt_x) begin
					cell_d[i] = dn_nb[i];
				end
			end else if (do_rot) begin
				// rotate the live part of the list by one toward the head
				if (CMPW'(i) + CMPW'(1) < cnt_x) begin
					cell_d[i] = dn_nb[i];
				end else if (CMPW'(i) + CMPW'(1) == cnt_x) begin
					cell_d[i] = cell_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_q[i] <= cell_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			pos_q  <= position;
			val_q  <= VAL_W'(value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (cmd.exec) begin
				idx_q <= '0;
				unique case (kind_q)
					KIND_INSERT: begin
						res_valid <= 1'b1;
						if (ins_ok) begin
							count_q <= count_q + CW'(1);
						end
					end
					KIND_DELETE: begin
						res_valid <= 1'b1;
						if (del_ok) begin
							count_q <= count_q - CW'(1);
						end
					end
					KIND_DUMP: begin
						res_valid <= (count_q == '0);
					end
					KIND_NOP: begin
						res_valid <= 1'b1;
					end
					default: begin
						res_valid <= 1'b1;
					end
				endcase
			end else if (cmd.step) begin
				idx_q     <= idx_q + CW'(1);
				res_valid <= (idx_x < CMPW'(DUMP_MAX));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_value <= '0;
			res_index <= '0;
			res_last  <= 1'b1;
			unique case (kind_q)
				KIND_INSERT: res_status <= full ? ST_FULL : (ins_ok ? ST_OK : ST_BADPOS);
				KIND_DELETE: res_status <= del_ok ? ST_OK : ST_BADPOS;
				KIND_DUMP:   res_status <= ST_EMPTY;
				KIND_NOP:    res_status <= ST_OK;
				default:     res_status <= ST_OK;
			endcase
		end else if (cmd.step) begin
			res_value  <= cell_q[0];
			res_index  <= IDX_W'(idx_q);
			res_status <= ST_OK;
			res_last   <= (idx_x + CMPW'(1) == nlim_x);
		end
	end

endmodule

/* rtl/positional_list_insert_delete_top.sv */
// channel      signals                                 handshake
// command in   kind, position, value                   start && !busy
// result out   item_value, item_index, status,         done strobe, one cycle,
//              entry_count, last                       receiver cannot stall
//
// insert, delete and no-op: busy during the execute state, result registered from it;
// the next command may be accepted while the result is shown
// dump: one entry per cycle from the head cell while the list rotates; a list
// longer than 32 entries keeps rotating unshown until it is back in order,
// so busy lasts until the rotation is complete
// reset clears the entry count, dump index, result strobe and controller state;
// cell contents are never read unwritten; depends on plid_pkg, plid_ctrl, plid_dp
module positional_list_insert_delete_top import plid_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic signed [VAL_W-1:0] item_value,
	output logic [IDX_W-1:0]        item_index,
	output logic [1:0]              status,
	output logic [CNT_OUT_W-1:0]    entry_count,
	output logic                    last
);

	localparam int CW = $clog2(DEPTH + 1);

	plid_cmd_t       cmd;
	plid_sts_t       sts;
	logic [CW-1:0]   count;

	plid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	plid_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.res_valid  (done),
		.res_value  (item_value),
		.res_index  (item_index),
		.res_status (status),
		.res_last   (last),
		.count      (count)
	);

	assign entry_count = CNT_OUT_W'(count);

	// results only come out of work started earlier
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> count == CW'(DEPTH))
		else $error("full status on a list that is not full");

	// a dump stream has no gaps until its last entry
	a_dump_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("dump stream broken before last entry");

endmodule

/* test/tb_positional_list_insert_delete_top.sv */
// self-checking testbench for positional_list_insert_delete_top
// holds its own list model and compares every result strobe against it
// depends on plid_pkg and the rtl of positional_list_insert_delete_top
module tb_positional_list_insert_delete_top;
	import plid_pkg::*;

	localparam int DEPTH       = 32;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [VAL_W-1:0]     val;
		logic [IDX_W-1:0]     idx;
		status_t              st;
		logic [CNT_OUT_W-1:0] cnt;
		logic                 last;
	} list_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              kind;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic                    done;
	logic signed [VAL_W-1:0] item_value;
	logic [IDX_W-1:0]        item_index;
	logic [1:0]              status;
	logic [CNT_OUT_W-1:0]    entry_count;
	logic                    last;

	logic [VAL_W-1:0] list_model[$];
	list_result_t     pending_results[$];
	list_result_t     got_exp;
	int               mismatch_count = 0;
	int               stall_cycles = 0;
	int               send_gap_pct = 0;

	positional_list_insert_delete_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.value(value),
		.done(done),
		.item_value(item_value),
		.item_index(item_index),
		.status(status),
		.entry_count(entry_count),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// update the list model for one accepted command and queue what it produces
	function automatic void apply_list_op(kind_t k, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
		list_result_t r;
		int n;
		int i;
		r.val  = '0;
		r.idx  = '0;
		r.st   = ST_OK;
		r.last = 1'b1;
		case (k)
		KIND_INSERT: begin
			if (list_model.size() >= DEPTH)
				r.st = ST_FULL;
			else if (int'(p) > list_model.size())
				r.st = ST_BADPOS;
			else
				list_model.insert(int'(p), v);
		end
		KIND_DELETE: begin
			if (int'(p) >= list_model.size())
				r.st = ST_BADPOS;
			else
				list_model.delete(int'(p));
		end
		KIND_DUMP: begin
			n = list_model.size();
			if (n == 0) begin
				r.st = ST_EMPTY;
			end else begin
				if (n > DUMP_MAX)
					n = DUMP_MAX;
				for (i = 0; i < n; i++) begin
					r.val  = list_model[i];
					r.idx  = IDX_W'(i);
					r.cnt  = CNT_OUT_W'(list_model.size());
					r.last = (i == n - 1);
					pending_results.push_back(r);
				end
				return;
			end
		end
		default: ;
		endcase
		r.cnt = CNT_OUT_W'(list_model.size());
		pending_results.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
			input logic [VAL_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %0h index %0d status %0d",
					$time, item_value, item_index, status);
				mismatch_count++;
			end else begin
				got_exp = pending_results.pop_front();
				check_field("item_value", got_exp.val, item_value);
				check_field("item_index", VAL_W'(got_exp.idx), VAL_W'(item_index));
				check_field("status", VAL_W'(got_exp.st), VAL_W'(status));
				check_field("entry_count", VAL_W'(got_exp.cnt), VAL_W'(entry_count));
				check_field("last", VAL_W'(got_exp.last), VAL_W'(last));
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[positional_list_insert_delete_top] ERROR");
			$finish;
		end
	end

	task automatic send_cmd(input kind_t k, input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		kind     <= k;
		position <= p;
		value    <= v;
		do @(posedge clk); while (busy);
		apply_list_op(k, p, v);
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(7))
		0: return 32'h7fff_ffff;
		1: return 32'h8000_0000;
		2: return 32'h0;
		3: return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_cmd(KIND_DUMP, 6'd0, 32'h0);
		send_cmd(KIND_DELETE, 6'd0, 32'h0);
		send_cmd(KIND_INSERT, 6'd1, 32'h1234_5678);
		send_cmd(KIND_INSERT, 6'd0, 32'h7fff_ffff);
		send_cmd(KIND_INSERT, 6'd1, 32'h8000_0000);
		send_cmd(KIND_INSERT, 6'd0, 32'h0);
		send_cmd(KIND_INSERT, 6'd1, 32'hffff_ffff);
		send_cmd(KIND_INSERT, 6'd63, 32'h5555_5555);
		send_cmd(KIND_INSERT, 6'd5, 32'haaaa_aaaa);
		send_cmd(KIND_DELETE, 6'd4, 32'h0);
		send_cmd(KIND_DELETE, 6'd63, 32'hffff_ffff);
		send_cmd(KIND_NOP, 6'd63, 32'hffff_ffff);
		send_cmd(KIND_NOP, 6'd0, 32'h0);
		send_cmd(KIND_DUMP, 6'd63, 32'hffff_ffff);
		send_cmd(KIND_DELETE, 6'd1, 32'h0);
		send_cmd(KIND_DELETE, 6'd2, 32'h0);
		send_cmd(KIND_DELETE, 6'd0, 32'h0);
		send_cmd(KIND_DUMP, 6'd0, 32'h0);
		send_cmd(KIND_DELETE, 6'd0, 32'h0);
		send_cmd(KIND_DUMP, 6'd0, 32'h0);
		send_cmd(KIND_INSERT, 6'd0, 32'h5555_5555);
		send_cmd(KIND_INSERT, 6'd0, 32'haaaa_aaaa);
		send_cmd(KIND_DUMP, 6'd0, 32'h0);
		send_cmd(KIND_DELETE, 6'd1, 32'h0);
		send_cmd(KIND_DELETE, 6'd0, 32'h0);
	endtask

	// grow to full with random positions, hit the full cases, then empty it again
	task automatic test_fill_and_drain();
		while (list_model.size() < DEPTH)
			send_cmd(KIND_INSERT, POS_W'($urandom_range(list_model.size())), $urandom);
		wait_results_drained();
		send_cmd(KIND_INSERT, 6'd0, rand_value());
		// full takes priority over a bad position
		send_cmd(KIND_INSERT, 6'd63, rand_value());
		send_cmd(KIND_INSERT, POS_W'(DEPTH), rand_value());
		send_cmd(KIND_DELETE, POS_W'(DEPTH), rand_value());
		send_cmd(KIND_DELETE, 6'd63, rand_value());
		send_cmd(KIND_DUMP, 6'd0, 32'h0);
		while (list_model.size() > 0) begin
			if ($urandom_range(7) == 0)
				send_cmd(KIND_DUMP, POS_W'($urandom_range(63)), $urandom);
			send_cmd(KIND_DELETE, POS_W'($urandom_range(list_model.size() - 1)), $urandom);
		end
	endtask

	task automatic test_random_ops(input int n_items, input int insert_pct);
		kind_t            k;
		logic [POS_W-1:0] p;
		logic [VAL_W-1:0] v;
		int               r;
		int               cnt;
		int               it;
		for (it = 0; it < n_items; it++) begin
			r   = $urandom_range(99);
			cnt = list_model.size();
			v   = rand_value();
			if (r < insert_pct) begin
				k = KIND_INSERT;
				p = POS_W'($urandom_range(cnt));
			end else if (r < 85) begin
				k = KIND_DELETE;
				p = (cnt == 0) ? '0 : POS_W'($urandom_range(cnt - 1));
			end else if (r < 92) begin
				k = KIND_DUMP;
				p = POS_W'($urandom_range(63));
			end else begin
				// noise: any kind code, any position
				k = kind_t'($urandom_range(3));
				p = POS_W'($urandom_range(63));
			end
			send_cmd(k, p, v);
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		kind     <= KIND_INSERT;
		position <= '0;
		value    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 21;
		test_directed();
		test_fill_and_drain();
		wait_results_drained();

		send_gap_pct = 49;
		test_random_ops(100, 50);
		wait_results_drained();

		send_gap_pct = 0;
		test_random_ops(100, 40);
		wait_results_drained();

		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("[positional_list_insert_delete_top] OK");
		else
			$display("[positional_list_insert_delete_top] ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/plid_pkg.sv
rtl/plid_ctrl.sv
rtl/plid_dp.sv
rtl/positional_list_insert_delete_top.sv
test/tb_positional_list_insert_delete_top.sv
